/* src/eims_pkg.sv */
// ----------------------------------------------------------------------------
// eims_pkg
// Shared widths, codes, command and status bundles, and the timebase tables
// of the edge interval measurement and scaling block.
// ----------------------------------------------------------------------------
package eims_pkg;

  // Width of the capture counter that the timestamps come from.
  localparam int TIME_WIDTH = 32;
  // Width of the scaled interval and of the 32-bit registers.
  localparam int VAL_W = 32;
  localparam int REG_W = 32;
  // Width of the largest timebase multiplier (15625).
  localparam int MUL_W = 14;
  // Width of the divisor: the bit period register.
  localparam int DIVISOR_W = REG_W;
  // Product of interval and multiplier.
  localparam int PROD_W = TIME_WIDTH + MUL_W;
  // Scaled value plus half a bit period, formed without wrap.
  localparam int ROUND_W = VAL_W + 1;
  // Dividend register of the rounding divider.
  localparam int DIV_W = ROUND_W;
  // Step counter of the rounding divider.
  localparam int CNT_W = $clog2(DIV_W + 1);
  // Width of the right shift applied to the product.
  localparam int SHIFT_W = 3;

  // One tick is 15625 ps. Per nanosecond this reduces to 125 / 8 and per
  // microsecond to 1 / 64, so the timebase divisions are plain shifts.
  localparam logic [MUL_W-1:0]   MUL_PS   = MUL_W'(15625);
  localparam logic [MUL_W-1:0]   MUL_NS   = MUL_W'(125);
  localparam logic [SHIFT_W-1:0] SHIFT_NS = SHIFT_W'(3);
  localparam logic [SHIFT_W-1:0] SHIFT_US = SHIFT_W'(6);

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_EDGE  = 2'd1,
    ACT_TICK  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_LOST    = 2'd1,
    STATUS_NO_EDGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    UNIT_TICKS = 2'd0,
    UNIT_PS    = 2'd1,
    UNIT_NS    = 2'd2,
    UNIT_US    = 2'd3
  } unit_e;

  typedef enum logic [1:0] {
    REG_UNIT_SELECT = 2'd0,
    REG_BIT_PERIOD  = 2'd1,
    REG_TIMEOUT     = 2'd2
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_UNIT,
    ST_ROUND,
    ST_DIV_BIT,
    ST_EMIT_LOST,
    ST_EMIT_VAL,
    ST_EMIT_NO_EDGE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     ld_start;
    logic     ld_edge;
    logic     ld_tick;
    logic     mul;
    logic     div_load;
    logic     div_step;
    logic     val_from_prod;
    logic     val_from_quot;
    logic     out_load;
    status_e  out_status;
    logic     out_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic level_same;
    logic tick_timeout;
    logic bit_round;
    logic div_busy;
    logic out_free;
  } sts_t;

  // Multiplier of the selected timebase.
  function automatic logic [MUL_W-1:0] unit_mul(input unit_e sel);
    logic [MUL_W-1:0] m;
    case (sel)
      UNIT_PS: m = MUL_PS;
      UNIT_NS: m = MUL_NS;
      default: m = MUL_W'(1);
    endcase
    return m;
  endfunction

  // Right shift of the product for the selected timebase.
  function automatic logic [SHIFT_W-1:0] unit_shift(input unit_e sel);
    logic [SHIFT_W-1:0] s;
    case (sel)
      UNIT_NS: s = SHIFT_NS;
      UNIT_US: s = SHIFT_US;
      default: s = SHIFT_W'(0);
    endcase
    return s;
  endfunction

endpackage

/* src/eims_datapath.sv */
// ----------------------------------------------------------------------------
// eims_datapath
// Holds the configuration registers, the edge reference, the timeout counter,
// the multiply and shift stage, a restoring divider for rounding to bit
// periods and the result register.
// ----------------------------------------------------------------------------
module eims_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  eims_pkg::cmd_t                 cmd_i,
  output eims_pkg::sts_t                 sts_o,
  input  logic [eims_pkg::REG_W-1:0]     timestamp_i,
  input  logic                           level_i,
  input  logic                           cfg_valid_i,
  input  logic [1:0]                     cfg_index_i,
  input  logic [eims_pkg::REG_W-1:0]     cfg_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     status_o,
  output logic [eims_pkg::VAL_W-1:0]     interval_o,
  output logic                           last_o
);

  localparam int TW = eims_pkg::TIME_WIDTH;
  localparam int DW = eims_pkg::DIV_W;
  localparam int SW = eims_pkg::DIVISOR_W;

  // Configuration registers.
  eims_pkg::unit_e              unit_q;
  logic [eims_pkg::REG_W-1:0]   bit_period_q;
  logic [eims_pkg::REG_W-1:0]   timeout_q;

  // Measurement state.
  logic [TW-1:0]                ref_q;
  logic                         level_q;
  logic [eims_pkg::REG_W-1:0]   wait_q;
  logic [eims_pkg::REG_W-1:0]   wait_inc;
  logic                         timeout_hit;

  // Arithmetic registers.
  logic [TW-1:0]                stamp;
  logic [TW-1:0]                delta_q;
  logic [eims_pkg::PROD_W-1:0]  prod_q;
  logic [eims_pkg::VAL_W-1:0]   value_q;
  logic [eims_pkg::ROUND_W-1:0] round_sum;

  // Divider registers.
  logic [DW-1:0]                dvd_q, dvd_d;
  logic [SW-1:0]                rem_q, rem_d;
  logic [SW-1:0]                dsr_q, dsr_d;
  logic [eims_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [SW:0]                  shifted;
  logic [SW:0]                  diff;
  logic                         fits;

  // Result register.
  logic                         out_valid_q;
  eims_pkg::status_e            status_q;
  logic [eims_pkg::VAL_W-1:0]   interval_q;
  logic                         last_q;
  logic                         out_free;

  assign stamp = timestamp_i[TW-1:0];

  // Saturating tick count and the timeout compare.
  assign wait_inc    = (wait_q == '1) ? wait_q : wait_q + eims_pkg::REG_W'(1);
  assign timeout_hit = wait_inc > timeout_q;

  // Scaled value plus half a bit period, one bit wider so that it cannot wrap.
  assign round_sum = eims_pkg::ROUND_W'(value_q) + eims_pkg::ROUND_W'(bit_period_q >> 1);

  assign out_free = !out_valid_q || !out_stall_i;

  // Status toward the controller.
  always_comb begin
    sts_o.level_same   = (level_i == level_q);
    sts_o.tick_timeout = timeout_hit;
    sts_o.bit_round    = bit_period_q > eims_pkg::REG_W'(1);
    sts_o.div_busy     = cnt_q != '0;
    sts_o.out_free     = out_free;
  end

  // Configuration writes; an index past the register list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q       <= eims_pkg::UNIT_TICKS;
      bit_period_q <= eims_pkg::REG_W'(1);
      timeout_q    <= '1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        eims_pkg::REG_UNIT_SELECT: unit_q       <= eims_pkg::unit_e'(cfg_data_i[1:0]);
        eims_pkg::REG_BIT_PERIOD:  bit_period_q <= cfg_data_i;
        eims_pkg::REG_TIMEOUT:     timeout_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Reference time, previous level and tick count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q   <= '0;
      level_q <= 1'b0;
      wait_q  <= '0;
    end else if (cmd_i.ld_start || cmd_i.ld_edge) begin
      ref_q   <= stamp;
      level_q <= level_i;
      wait_q  <= '0;
    end else if (cmd_i.ld_tick) begin
      wait_q  <= timeout_hit ? '0 : wait_inc;
    end
  end

  // Interval, product and scaled value; the timebase division is a shift.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_edge) begin
      delta_q <= stamp - ref_q;
    end
    if (cmd_i.mul) begin
      prod_q <= eims_pkg::PROD_W'(delta_q) * eims_pkg::PROD_W'(eims_pkg::unit_mul(unit_q));
    end
    if (cmd_i.val_from_prod) begin
      value_q <= eims_pkg::VAL_W'(prod_q >> eims_pkg::unit_shift(unit_q));
    end else if (cmd_i.val_from_quot) begin
      value_q <= dvd_q[eims_pkg::VAL_W-1:0];
    end
  end

  // One restoring step: the quotient bits shift in at the bottom of the dividend.
  assign shifted = {rem_q, dvd_q[DW-1]};
  assign diff    = shifted - {1'b0, dsr_q};
  assign fits    = shifted >= {1'b0, dsr_q};

  always_comb begin
    dvd_d = dvd_q;
    rem_d = rem_q;
    dsr_d = dsr_q;
    cnt_d = cnt_q;
    if (cmd_i.div_load) begin
      rem_d = '0;
      dvd_d = round_sum;
      dsr_d = bit_period_q;
      cnt_d = eims_pkg::CNT_W'(DW);
    end else if (cmd_i.div_step) begin
      rem_d = fits ? diff[SW-1:0] : shifted[SW-1:0];
      dvd_d = {dvd_q[DW-2:0], fits};
      cnt_d = cnt_q - eims_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  // Result register: a new result is loaded only when the slot frees up.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_q   <= cmd_i.out_status;
      interval_q <= (cmd_i.out_status == eims_pkg::STATUS_OK) ? value_q : '0;
      last_q     <= cmd_i.out_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign interval_o  = interval_q;
  assign last_o      = last_q;

endmodule

/* src/eims_ctrl.sv */
// ----------------------------------------------------------------------------
// eims_ctrl
// Sequencer of the block: accepts one request at a time, steps the datapath
// through multiply, timebase shift, rounding to bit periods and result
// delivery.
// ----------------------------------------------------------------------------
module eims_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [1:0]     action_i,
  input  eims_pkg::sts_t sts_i,
  output eims_pkg::cmd_t cmd_o
);

  eims_pkg::state_e state_q, state_d;
  logic             lost_q, lost_d;
  logic             accept;

  // Requests are taken only while the sequencer waits for work.
  assign in_stall_o = (state_q != eims_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= eims_pkg::ST_IDLE;
      lost_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      lost_q  <= lost_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    lost_d  = lost_q;
    cmd_o   = '0;
    unique case (state_q)
      eims_pkg::ST_IDLE: begin
        if (accept) begin
          case (action_i)
            eims_pkg::ACT_START: begin
              cmd_o.ld_start = 1'b1;
            end
            eims_pkg::ACT_EDGE: begin
              cmd_o.ld_edge = 1'b1;
              lost_d        = sts_i.level_same;
              state_d       = eims_pkg::ST_MUL;
            end
            eims_pkg::ACT_TICK: begin
              cmd_o.ld_tick = 1'b1;
              if (sts_i.tick_timeout) begin
                state_d = eims_pkg::ST_EMIT_NO_EDGE;
              end
            end
            default: ;
          endcase
        end
      end
      eims_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = eims_pkg::ST_UNIT;
      end
      eims_pkg::ST_UNIT: begin
        cmd_o.val_from_prod = 1'b1;
        state_d             = eims_pkg::ST_ROUND;
      end
      eims_pkg::ST_ROUND: begin
        if (sts_i.bit_round) begin
          cmd_o.div_load = 1'b1;
          state_d        = eims_pkg::ST_DIV_BIT;
        end else begin
          state_d = lost_q ? eims_pkg::ST_EMIT_LOST : eims_pkg::ST_EMIT_VAL;
        end
      end
      eims_pkg::ST_DIV_BIT: begin
        if (sts_i.div_busy) begin
          cmd_o.div_step = 1'b1;
        end else begin
          cmd_o.val_from_quot = 1'b1;
          state_d = lost_q ? eims_pkg::ST_EMIT_LOST : eims_pkg::ST_EMIT_VAL;
        end
      end
      eims_pkg::ST_EMIT_LOST: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = eims_pkg::STATUS_LOST;
          cmd_o.out_last   = 1'b0;
          state_d          = eims_pkg::ST_EMIT_VAL;
        end
      end
      eims_pkg::ST_EMIT_VAL: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = eims_pkg::STATUS_OK;
          cmd_o.out_last   = 1'b1;
          state_d          = eims_pkg::ST_IDLE;
        end
      end
      eims_pkg::ST_EMIT_NO_EDGE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = eims_pkg::STATUS_NO_EDGE;
          cmd_o.out_last   = 1'b1;
          state_d          = eims_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = eims_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // A result is never loaded over one that the receiver still holds off.
  a_load_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded while the output register was stalled");

  // The divider is stepped only while it has steps left.
  a_step_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_step |-> sts_i.div_busy)
    else $error("divider stepped after its last step");

  // A lost-edge result is always followed by the interval of the same edge.
  a_lost_then_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_load && cmd_o.out_status == eims_pkg::STATUS_LOST)
      |=> state_q == eims_pkg::ST_EMIT_VAL)
    else $error("lost-edge result not followed by its interval");

  // A freshly loaded division always has work to do on the next cycle.
  a_load_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_load |=> sts_i.div_busy)
    else $error("division loaded with no steps");
`endif

endmodule

/* src/edge_interval_measure_scale_core.sv */
// ----------------------------------------------------------------------------
// edge_interval_measure_scale_core
// Measures the time between captured pin edges, scales it to the selected
// timebase, optionally rounds it to whole bit periods, and reports timeouts.
// ----------------------------------------------------------------------------
// Usage:
// Input requests (action, timestamp, level) arrive on in_valid_i and are
// taken on a clock edge with in_valid_i high and in_stall_o low. A start
// request loads the reference and gives no result; an edge request gives one
// result, or two when the level did not toggle (lost edge first, last low);
// a tick request gives a no-edge result when the timeout is exceeded.
// Results leave through a register on out_valid_o and are taken when
// out_stall_i is low; while the receiver stalls the result holds and the
// block waits before loading the next one.
// Start requests and ticks that do not time out finish in their accepting
// cycle; a tick that times out holds the input off until its no-edge result
// is loaded. An edge request holds the input off through the multiply,
// timebase shift, rounding check and result load, when the bit period is
// above one also through the 33 divider steps and the quotient load, and
// through one more result load for a lost edge; its interval is then on the
// output. Stalls by the receiver lengthen this. One request is in flight.
// Configuration writes on cfg_valid_i are always ready; the user must make them
// while the block is idle, which the block does not enforce. Reset clears the
// reference, level and tick count, and sets raw ticks, bit period 1, no timeout.
// ----------------------------------------------------------------------------
module edge_interval_measure_scale_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 action_i,
  input  logic [eims_pkg::REG_W-1:0] timestamp_i,
  input  logic                       level_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [eims_pkg::VAL_W-1:0] interval_o,
  output logic                       last_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [1:0]                 cfg_index_i,
  input  logic [eims_pkg::REG_W-1:0] cfg_data_i
);

  eims_pkg::cmd_t cmd;
  eims_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  // Sequencer.
  eims_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Registers, arithmetic and result register.
  eims_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .timestamp_i (timestamp_i),
    .level_i     (level_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .interval_o  (interval_o),
    .last_o      (last_o)
  );

endmodule
